// ===== hdl/ffsa_pkg.sv =====
// Shared types, constants and field widths of the first-fit segment allocator.
// Used by ffsa_ctrl, ffsa_dp and first_fit_segment_allocator; depends on nothing.
package ffsa_pkg;

    localparam int SEGMENTS_DEF      = 64;
    localparam int MAX_RESOURCES_DEF = 256;

    localparam int SEG_W    = 7;
    localparam int COUNT_W  = 9;
    localparam int STATUS_W = 2;
    localparam int INDEX_W  = 8;
    localparam int GROUP_W  = 3;
    localparam int POS_W    = 6;

    localparam logic [COUNT_W-1:0] COUNT_RESET = COUNT_W'(200);
    localparam logic [POS_W-1:0]   GROUP_SIZE  = POS_W'(50);

    localparam logic [STATUS_W-1:0] ST_GRANTED = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    typedef struct packed {
        logic start;
        logic scan;
        logic clear;
        logic finish;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic done;
        logic clear_last;
    } t_dp_status;

endpackage

// ===== hdl/ffsa_ctrl.sv =====
// Control state machine of the allocator: clearing pass, request sequencing and
// output handshake. Depends on ffsa_pkg.
module ffsa_ctrl
    import ffsa_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_ready,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    input  t_dp_status i_status,
    output t_dp_cmd    o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_SCAN  = 2'd2;
    localparam logic [1:0] S_DONE  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        case (r_state)
            S_CLEAR: begin
                o_cmd.clear = 1'b1;
                if (i_status.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.start = 1'b1;
                    n_state     = S_SCAN;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_status.done) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_out_valid = r_out_valid;

endmodule

// ===== hdl/ffsa_dp.sv =====
// Datapath of the allocator: occupancy memory, pipelined scan, group/position
// counters, count register and result registers. Depends on ffsa_pkg.
module ffsa_dp
    import ffsa_pkg::*;
#(
    parameter int SEGMENTS      = SEGMENTS_DEF,
    parameter int MAX_RESOURCES = MAX_RESOURCES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_wdata,
    input  logic [SEG_W-1:0]    i_first_segment,
    input  logic [SEG_W-1:0]    i_end_segment,
    input  t_dp_cmd             i_cmd,
    output t_dp_status          o_status,
    output logic [STATUS_W-1:0] o_status_code,
    output logic [INDEX_W-1:0]  o_resource_index,
    output logic [GROUP_W-1:0]  o_group_number,
    output logic [POS_W-1:0]    o_position_in_group
);

    localparam int IW = (MAX_RESOURCES > 1) ? $clog2(MAX_RESOURCES) : 1;
    localparam int CW = $clog2(MAX_RESOURCES + 1);
    localparam int LW = (CW > COUNT_W) ? CW : COUNT_W;

    logic [SEGMENTS-1:0] r_mem [MAX_RESOURCES];
    logic [SEGMENTS-1:0] r_rd_data;

    logic [COUNT_W-1:0]  r_count;
    logic [SEGMENTS-1:0] r_mask;
    logic                r_bad;
    logic [CW-1:0]       r_addr;
    logic [GROUP_W-1:0]  r_grp;
    logic [POS_W-1:0]    r_pos;
    logic                r_pend;
    logic [IW-1:0]       r_pend_idx;
    logic [GROUP_W-1:0]  r_pend_grp;
    logic [POS_W-1:0]    r_pend_pos;

    logic [STATUS_W-1:0] r_res_status;
    logic [INDEX_W-1:0]  r_res_index;
    logic [GROUP_W-1:0]  r_res_grp;
    logic [POS_W-1:0]    r_res_pos;

    logic [SEGMENTS-1:0] req_mask;
    logic                req_bad;
    logic [LW-1:0]       count_ext;
    logic [LW-1:0]       limit;
    logic                more;
    logic                hit;
    logic                exhausted;
    logic [IW-1:0]       rd_idx;
    logic                mem_we;
    logic [IW-1:0]       wr_idx;
    logic [SEGMENTS-1:0] wr_data;

    always_comb begin
        for (int b = 0; b < SEGMENTS; b++) begin
            req_mask[b] = (SEG_W'(b) >= i_first_segment) && (SEG_W'(b) < i_end_segment);
        end
        req_bad = (i_first_segment >= i_end_segment) || (i_end_segment > SEG_W'(SEGMENTS));
    end

    assign count_ext = LW'(r_count);
    assign limit     = (count_ext > LW'(MAX_RESOURCES)) ? LW'(MAX_RESOURCES) : count_ext;
    assign more      = LW'(r_addr) < limit;
    assign hit       = r_pend && ((r_rd_data & r_mask) == '0);
    assign exhausted = !r_pend && !more;

    assign o_status.done       = r_bad || hit || exhausted;
    assign o_status.clear_last = (r_addr == CW'(MAX_RESOURCES - 1));

    assign rd_idx  = r_addr[IW-1:0];
    assign mem_we  = i_cmd.clear || (i_cmd.scan && hit && !r_bad);
    assign wr_idx  = i_cmd.clear ? r_addr[IW-1:0] : r_pend_idx;
    assign wr_data = i_cmd.clear ? '0 : (r_rd_data | r_mask);

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_idx] <= wr_data;
        end
        r_rd_data <= r_mem[rd_idx];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= COUNT_RESET;
        end else if (i_cfg_we) begin
            r_count <= i_cfg_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.clear) begin
            r_addr <= r_addr + CW'(1);
            r_pend <= 1'b0;
        end else if (i_cmd.start) begin
            r_addr <= '0;
            r_pend <= 1'b0;
        end else if (i_cmd.scan) begin
            r_pend <= more;
            if (more) begin
                r_addr <= r_addr + CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mask <= req_mask;
            r_bad  <= req_bad;
            r_grp  <= GROUP_W'(1);
            r_pos  <= POS_W'(1);
        end else if (i_cmd.scan && more) begin
            r_pend_idx <= r_addr[IW-1:0];
            r_pend_grp <= r_grp;
            r_pend_pos <= r_pos;
            if (r_pos == GROUP_SIZE) begin
                r_pos <= POS_W'(1);
                r_grp <= r_grp + GROUP_W'(1);
            end else begin
                r_pos <= r_pos + POS_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.finish) begin
            if (r_bad) begin
                r_res_status <= ST_INVALID;
                r_res_index  <= '0;
                r_res_grp    <= '0;
                r_res_pos    <= '0;
            end else if (hit) begin
                r_res_status <= ST_GRANTED;
                r_res_index  <= INDEX_W'(r_pend_idx);
                r_res_grp    <= r_pend_grp;
                r_res_pos    <= r_pend_pos;
            end else begin
                r_res_status <= ST_FULL;
                r_res_index  <= '0;
                r_res_grp    <= '0;
                r_res_pos    <= '0;
            end
        end
        if (i_cmd.load_out) begin
            o_status_code       <= r_res_status;
            o_resource_index    <= r_res_index;
            o_group_number      <= r_res_grp;
            o_position_in_group <= r_res_pos;
        end
    end

endmodule

// ===== hdl/first_fit_segment_allocator.sv =====
// Top level of the first-fit segment allocator: joins controller and datapath.
// Depends on ffsa_pkg, ffsa_ctrl and ffsa_dp.
//
//   Channel   Handshake                 Payload
//   in        i_in_valid / o_in_ready   i_first_segment, i_end_segment
//   out       o_out_valid / i_out_ready o_status, o_resource_index,
//                                       o_group_number, o_position_in_group
//   cfg       i_cfg_we                  i_cfg_wdata (resource_count)
//
// An invalid item is refused without a scan; a valid item is granted at the first
// index k whose word is free in the requested segments, and is refused when no index
// below min(resource_count, MAX_RESOURCES) fits. The scan reads one occupancy word
// per cycle. After reset a clearing pass writes MAX_RESOURCES words, one per
// cycle, before the first item is accepted. While a result is held, the next result
// waits in the datapath's result registers; no further item is accepted until loaded.
module first_fit_segment_allocator
    import ffsa_pkg::*;
#(
    parameter int SEGMENTS      = SEGMENTS_DEF,
    parameter int MAX_RESOURCES = MAX_RESOURCES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [COUNT_W-1:0]  i_cfg_wdata,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [SEG_W-1:0]    i_first_segment,
    input  logic [SEG_W-1:0]    i_end_segment,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [INDEX_W-1:0]  o_resource_index,
    output logic [GROUP_W-1:0]  o_group_number,
    output logic [POS_W-1:0]    o_position_in_group
);

    t_dp_cmd    cmd;
    t_dp_status status;

    ffsa_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    ffsa_dp #(
        .SEGMENTS      (SEGMENTS),
        .MAX_RESOURCES (MAX_RESOURCES)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_we            (i_cfg_we),
        .i_cfg_wdata         (i_cfg_wdata),
        .i_first_segment     (i_first_segment),
        .i_end_segment       (i_end_segment),
        .i_cmd               (cmd),
        .o_status            (status),
        .o_status_code       (o_status),
        .o_resource_index    (o_resource_index),
        .o_group_number      (o_group_number),
        .o_position_in_group (o_position_in_group)
    );

    a_cmd_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({cmd.start, cmd.clear, cmd.load_out, cmd.scan}))
        else $error("Controller issued conflicting datapath commands.");

    a_refused_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status != ST_GRANTED)) |->
        (o_resource_index == '0 && o_group_number == '0 && o_position_in_group == '0))
        else $error("Refused item carries a nonzero index.");

    a_granted_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == ST_GRANTED)) |->
        (o_position_in_group != '0 && o_position_in_group <= GROUP_SIZE))
        else $error("Granted item has a position outside its group.");

    a_no_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.start |=> !o_in_ready)
        else $error("Item accepted while a scan is in progress.");

endmodule
